/* src/mau_pkg.sv */
`timescale 1ns / 1ps

package mau_pkg;

	// Operation codes carried in req_type
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_POW = 3'd4;

	// Field widths fixed by the interface
	localparam int A_W    = 32;
	localparam int B_W    = 64;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	// Step counter covers the 64 bits of the wide operand
	localparam int CNT_W = 7;

	// Modulus after reset
	localparam logic [DATA_W-1:0] MOD_RESET = 32'd1000000007;

	// paddr[2] selects the register; only the modulus exists
	localparam logic REG_MODULUS = 1'b0;

	// Return targets of the shared multiply sequence
	localparam logic [1:0] RET_RES = 2'd0;
	localparam logic [1:0] RET_ACC = 2'd1;
	localparam logic [1:0] RET_SQ  = 2'd2;

endpackage

/* src/modular_arithmetic_unit_top.sv */
// Modular arithmetic unit: each input word (req_type, operand_a, operand_b) yields one
// residue modulo the programmed modulus (register 0, reset 1000000007); add, subtract,
// multiply, divide by Fermat inverse (prime modulus assumed, divisor zero gives zero) and
// power with a raw 64-bit exponent; unknown codes or a modulus below two give zero. All
// arithmetic but the final subtract runs through one add-and-reduce unit that does one
// step per cycle: the operands are reduced bit by bit, and a multiply is done by shift
// and add. One word is worked on at a time; the input is stalled until its result is
// loaded into the output register.
`timescale 1ns / 1ps

module modular_arithmetic_unit_top
	import mau_pkg::*;
#(
	parameter int MOD_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        req_type,
	input  logic [A_W-1:0]    operand_a,
	input  logic [B_W-1:0]    operand_b,

	output logic              out_valid,
	input  logic              out_stall,
	output logic [DATA_W-1:0] residue,

	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RED_A = 3'd1;
	localparam logic [2:0] S_RED_B = 3'd2;
	localparam logic [2:0] S_DISP  = 3'd3;
	localparam logic [2:0] S_PCHK  = 3'd4;
	localparam logic [2:0] S_MUL   = 3'd5;
	localparam logic [2:0] S_RET   = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	localparam logic [MOD_BITS-1:0] ONE = MOD_BITS'(1);
	localparam logic [MOD_BITS-1:0] TWO = MOD_BITS'(2);

	logic [2:0]          state_q;
	logic [MOD_BITS-1:0] mod_q;
	logic [2:0]          op_q;
	logic [A_W-1:0]      a_q;
	logic [B_W-1:0]      b_q;
	logic [MOD_BITS-1:0] ra_q, rb_q, acc_q, sq_q, work_q, mx_q, my_q, res_q, residue_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                add_q;
	logic [1:0]          ret_q;
	logic                vout_q;

	logic [MOD_BITS-1:0] u_x, u_y, u_r;
	logic                u_cin;
	logic [MOD_BITS-1:0] sub_v;
	logic                out_free;
	logic                load_out;

	// Config port
	assign pready = 1'b1;
	assign prdata = DATA_W'(mod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MOD_RESET[MOD_BITS-1:0];
		end else if (psel && penable && pwrite && paddr[2] == REG_MODULUS) begin
			mod_q <= pwdata[MOD_BITS-1:0];
		end
	end

	// Shared add-and-reduce unit
	mau_addmod #(.W(MOD_BITS)) u_addmod (
		.x   (u_x),
		.y   (u_y),
		.cin (u_cin),
		.m   (mod_q),
		.r   (u_r)
	);

	always_comb begin
		u_x   = work_q;
		u_y   = work_q;
		u_cin = 1'b0;
		unique case (state_q)
			S_RED_A: u_cin = a_q[A_W-1];
			S_RED_B: u_cin = b_q[B_W-1];
			S_MUL: begin
				if (add_q) u_y = mx_q;
			end
			S_DISP: begin
				u_x = ra_q;
				u_y = rb_q;
			end
			default: begin
				u_x   = work_q;
				u_y   = work_q;
				u_cin = 1'b0;
			end
		endcase
	end

	// subtract: wrap by the modulus when it borrows
	assign sub_v = ra_q - rb_q + ((ra_q < rb_q) ? mod_q : '0);

	// Handshake
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = vout_q;
	assign residue   = DATA_W'(residue_q);
	assign out_free  = !vout_q || !out_stall;
	assign load_out  = (state_q == S_OUT) && out_free;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vout_q  <= 1'b0;
		end else begin
			// output word stays until taken, a new one loads when the register is free
			vout_q <= load_out || (vout_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q   <= req_type;
						a_q    <= operand_a;
						b_q    <= operand_b;
						work_q <= '0;
						cnt_q  <= CNT_W'(A_W);
						if (mod_q < TWO || req_type > OP_POW) begin
							res_q   <= '0;
							state_q <= S_OUT;
						end else begin
							state_q <= S_RED_A;
						end
					end
				end
				// reduce operand_a one bit per cycle
				S_RED_A: begin
					work_q <= u_r;
					a_q    <= {a_q[A_W-2:0], 1'b0};
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						ra_q    <= u_r;
						work_q  <= '0;
						cnt_q   <= CNT_W'(B_W);
						state_q <= S_RED_B;
					end
				end
				// reduce operand_b; rotate so the raw exponent survives
				S_RED_B: begin
					work_q <= u_r;
					b_q    <= {b_q[B_W-2:0], b_q[B_W-1]};
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						rb_q    <= u_r;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					acc_q <= ONE;
					unique case (op_q)
						OP_ADD: begin
							res_q   <= u_r;
							state_q <= S_OUT;
						end
						OP_SUB: begin
							res_q   <= sub_v;
							state_q <= S_OUT;
						end
						OP_MUL: begin
							mx_q    <= ra_q;
							my_q    <= rb_q;
							work_q  <= '0;
							cnt_q   <= CNT_W'(MOD_BITS);
							add_q   <= 1'b0;
							ret_q   <= RET_RES;
							state_q <= S_MUL;
						end
						OP_DIV: begin
							if (rb_q == '0) begin
								res_q   <= '0;
								state_q <= S_OUT;
							end else begin
								sq_q    <= rb_q;
								b_q     <= B_W'(mod_q - TWO);
								state_q <= S_PCHK;
							end
						end
						default: begin
							sq_q    <= ra_q;
							state_q <= S_PCHK;
						end
					endcase
				end
				// square-and-multiply step, exponent scanned from its low bit
				S_PCHK: begin
					work_q <= '0;
					cnt_q  <= CNT_W'(MOD_BITS);
					add_q  <= 1'b0;
					if (b_q == '0) begin
						if (op_q == OP_DIV) begin
							mx_q    <= ra_q;
							my_q    <= acc_q;
							ret_q   <= RET_RES;
							state_q <= S_MUL;
						end else begin
							res_q   <= acc_q;
							state_q <= S_OUT;
						end
					end else if (b_q[0]) begin
						mx_q    <= sq_q;
						my_q    <= acc_q;
						ret_q   <= RET_ACC;
						state_q <= S_MUL;
					end else begin
						mx_q    <= sq_q;
						my_q    <= sq_q;
						ret_q   <= RET_SQ;
						state_q <= S_MUL;
					end
				end
				// shift-and-add modular multiply: double, then add when the bit is set
				S_MUL: begin
					work_q <= u_r;
					if (!add_q && my_q[MOD_BITS-1]) begin
						add_q <= 1'b1;
					end else begin
						add_q <= 1'b0;
						my_q  <= {my_q[MOD_BITS-2:0], 1'b0};
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == CNT_W'(1)) state_q <= S_RET;
					end
				end
				S_RET: begin
					unique case (ret_q)
						RET_ACC: begin
							acc_q   <= work_q;
							mx_q    <= sq_q;
							my_q    <= sq_q;
							work_q  <= '0;
							cnt_q   <= CNT_W'(MOD_BITS);
							add_q   <= 1'b0;
							ret_q   <= RET_SQ;
							state_q <= S_MUL;
						end
						RET_SQ: begin
							sq_q    <= work_q;
							b_q     <= {1'b0, b_q[B_W-1:1]};
							state_q <= S_PCHK;
						end
						default: begin
							res_q   <= work_q;
							state_q <= S_OUT;
						end
					endcase
				end
				// hand the result to the output register once it is free
				S_OUT: begin
					if (out_free) begin
						residue_q <= res_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* src/mau_addmod.sv */
`timescale 1ns / 1ps

// r = (x + y + cin) mod m, valid when x + y + cin < 2*m
module mau_addmod #(
	parameter int W = 32
) (
	input  logic [W-1:0] x,
	input  logic [W-1:0] y,
	input  logic         cin,
	input  logic [W-1:0] m,
	output logic [W-1:0] r
);

	logic [W:0] sum;
	logic [W:0] dif;

	// one wide add, then a single conditional subtract of the modulus
	assign sum = {1'b0, x} + {1'b0, y} + {{W{1'b0}}, cin};
	assign dif = sum - {1'b0, m};
	assign r   = (sum >= {1'b0, m}) ? dif[W-1:0] : sum[W-1:0];

endmodule
